// File: hdl/gpsm_pkg.sv
// Shared types and constants for the grid peak SAD matcher.
package gpsm_pkg;

  // Store geometry; fixed by the 8-bit positions and 9-bit size registers
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int MAX_SUB    = 64;

  typedef enum logic [1:0] {
    REQ_LOAD_LARGE = 2'd0,
    REQ_LOAD_SUB   = 2'd1,
    REQ_START      = 2'd2,
    REQ_NONE       = 2'd3
  } req_t;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_SUB    = 2'd2;

  localparam int CFG_IDX_W = 2;
  localparam int SAD_W     = 21;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  pos_x;
    logic [7:0]  pos_y;
    logic [7:0]  pixel;
    logic signed [31:0] corr_score;
  } in_word_t;

  typedef struct packed {
    logic        found;
    logic [7:0]  match_x;
    logic [7:0]  match_y;
    logic [20:0] best_sad;
  } out_word_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [8:0]           data;
  } cfg_word_t;

endpackage

// File: hdl/gpsm_if.sv
// Valid/ready channel interfaces for the grid peak SAD matcher.
interface gpsm_in_if;
  logic                 valid;
  logic                 ready;
  gpsm_pkg::in_word_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface gpsm_out_if;
  logic                 valid;
  logic                 ready;
  gpsm_pkg::out_word_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface gpsm_cfg_if;
  logic                 valid;
  logic                 ready;
  gpsm_pkg::cfg_word_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/grid_peak_sad_template_match_top.sv
// Top level of the grid peak SAD template matcher.
//
// Channels: in (load large pixel, load sub-image pixel, start), out (one
// result word per start), cfg (register writes, taken only while idle).
// Loads are accepted one per cycle while idle and write the stores at the accepting edge.
// A start walks every cell: one memory read per cycle from the score store
// for the peak scan, then one read per cycle from the pixel and sub-image
// stores for the SAD. A cell whose peak window runs off the image skips
// the SAD. The cost is set by the single read port of each store.
// The result sits in an output register; while the receiver stalls, loads
// are still taken, but a further start waits until the result is gone.
// Reset: registers go to width 256, height 256, sub size 16; the stores
// keep whatever they held (undefined until written), no clearing pass.
module grid_peak_sad_template_match_top (
  input  logic clk,
  input  logic rst_n,
  gpsm_in_if.sink    in_ch,
  gpsm_out_if.source out_ch,
  gpsm_cfg_if.sink   cfg_ch
);
  import gpsm_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int SW = $clog2(MAX_SUB);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int SSW = $clog2(MAX_SUB + 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_PEAK, ST_PEAK_END, ST_SAD, ST_SAD_END, ST_NEXT, ST_DONE
  } state_t;

  // Memories
  logic [7:0]  large_mem [MAX_WIDTH*MAX_HEIGHT];
  logic [31:0] corr_mem  [MAX_WIDTH*MAX_HEIGHT];
  logic [7:0]  sub_mem   [MAX_SUB*MAX_SUB];

  logic [8:0] width_r, height_r;
  logic [6:0] sub_r;

  state_t state_r;
  logic [WW-1:0]  w_c;
  logic [HW-1:0]  h_c;
  logic [SSW-1:0] s_c;
  logic [WW+1:0]  xl_r, yl_r;      // cell origin
  logic [SSW-1:0] ix_r, iy_r;      // inner counters
  logic [WW+1:0]  px_r, py_r;      // peak position
  logic [31:0]    peak_r;
  logic           pv_r;            // read data of the previous cycle valid
  logic [WW+1:0]  rx_r, ry_r;      // address that read data belongs to
  logic           first_r;
  logic [SAD_W:0] sad_r, best_r;
  logic [7:0]     bx_r, by_r;
  logic           found_r;
  logic [31:0]    corr_q;
  logic [7:0]     large_q, sub_q;
  logic           out_v_r;
  out_word_t      out_r;

  // Clamped register values
  always_comb begin
    w_c = (width_r == '0) ? WW'(1) : (32'(width_r) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(width_r);
    h_c = (height_r == '0) ? HW'(1) :
          (32'(height_r) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(height_r);
    s_c = (sub_r == '0) ? SSW'(1) : (32'(sub_r) > MAX_SUB) ? SSW'(MAX_SUB) : SSW'(sub_r);
  end

  wire in_fire = in_ch.valid && in_ch.ready;
  wire [1:0] rq = in_ch.data.req_type;
  assign in_ch.ready = (state_r == ST_IDLE) && !(rq == REQ_START && out_v_r);
  assign cfg_ch.ready = (state_r == ST_IDLE);
  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_r;

  // Config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= 9'd256; height_r <= 9'd256; sub_r <= 7'd16;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.data.index)
        CFG_WIDTH:  width_r  <= cfg_ch.data.data;
        CFG_HEIGHT: height_r <= cfg_ch.data.data;
        CFG_SUB:    sub_r    <= cfg_ch.data.data[6:0];
        default: ;
      endcase
    end
  end

  // Read addresses
  logic [WW+1:0] cx, cy, lx, ly;
  logic [XW+YW-1:0] big_ra;
  logic [2*SW-1:0]  sub_ra;
  always_comb begin
    cx = xl_r + (WW+2)'(ix_r);
    cy = yl_r + (WW+2)'(iy_r);
    lx = px_r + (WW+2)'(ix_r);
    ly = py_r + (WW+2)'(iy_r);
    if (state_r == ST_SAD) big_ra = {ly[YW-1:0], lx[XW-1:0]};
    else                   big_ra = {cy[YW-1:0], cx[XW-1:0]};
    sub_ra = {iy_r[SW-1:0], ix_r[SW-1:0]};
  end

  // Store writes and reads
  wire in_x_ok  = 32'(in_ch.data.pos_x) < MAX_WIDTH  && 32'(in_ch.data.pos_y) < MAX_HEIGHT;
  wire in_s_ok  = 32'(in_ch.data.pos_x) < MAX_SUB    && 32'(in_ch.data.pos_y) < MAX_SUB;
  always_ff @(posedge clk) begin
    if (in_fire && rq == REQ_LOAD_LARGE && in_x_ok) begin
      large_mem[{YW'(in_ch.data.pos_y), XW'(in_ch.data.pos_x)}] <= in_ch.data.pixel;
      corr_mem[{YW'(in_ch.data.pos_y), XW'(in_ch.data.pos_x)}]  <= in_ch.data.corr_score;
    end
    if (in_fire && rq == REQ_LOAD_SUB && in_s_ok)
      sub_mem[{SW'(in_ch.data.pos_y), SW'(in_ch.data.pos_x)}] <= in_ch.data.pixel;
    corr_q  <= corr_mem[big_ra];
    large_q <= large_mem[big_ra];
    sub_q   <= sub_mem[sub_ra];
  end

  // Inner counter step: y inner, x outer
  wire last_y = (iy_r == s_c - SSW'(1));
  wire last_xy = last_y && (ix_r == s_c - SSW'(1));
  logic [7:0] dif;
  assign dif = (sub_q > large_q) ? sub_q - large_q : large_q - sub_q;

  // Search sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; out_v_r <= 1'b0; pv_r <= 1'b0;
    end else begin
      if (out_ch.ready && out_v_r) out_v_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_fire && rq == REQ_START) begin
            xl_r <= '0; yl_r <= '0; found_r <= 1'b0;
            best_r <= (SAD_W+1)'(32'(s_c) * 32'(s_c) * 256);
            bx_r <= '0; by_r <= '0;
            ix_r <= '0; iy_r <= '0; pv_r <= 1'b0; first_r <= 1'b1;
            state_r <= ST_NEXT;
          end
        end
        ST_NEXT: begin
          // check that the cell fits: past the last column finish, past the last row go to the next column
          if (xl_r + (WW+2)'(s_c) > (WW+2)'(w_c)) begin
            state_r <= ST_DONE;
          end else if (yl_r + (WW+2)'(s_c) > (WW+2)'(h_c)) begin
            xl_r <= xl_r + (WW+2)'(s_c); yl_r <= '0;
          end else begin
            ix_r <= '0; iy_r <= '0; pv_r <= 1'b0; first_r <= 1'b1;
            state_r <= ST_PEAK;
          end
        end
        ST_PEAK, ST_PEAK_END: begin
          if (pv_r) begin
            first_r <= 1'b0;
            if (first_r || ((corr_q ^ 32'h8000_0000) > (peak_r ^ 32'h8000_0000))) begin
              peak_r <= corr_q; px_r <= rx_r; py_r <= ry_r;
            end
          end
          if (state_r == ST_PEAK) begin
            pv_r <= 1'b1; rx_r <= cx; ry_r <= cy;
            if (last_xy) state_r <= ST_PEAK_END;
            if (last_y) begin
              iy_r <= '0; ix_r <= ix_r + SSW'(1);
            end else iy_r <= iy_r + SSW'(1);
          end else begin
            pv_r <= 1'b0; ix_r <= '0; iy_r <= '0; sad_r <= '0;
            state_r <= ST_SAD;
          end
        end
        ST_SAD, ST_SAD_END: begin
          if (state_r == ST_SAD && pv_r == 1'b0 && ix_r == '0 && iy_r == '0 &&
              (px_r + (WW+2)'(s_c) > (WW+2)'(w_c) ||
               py_r + (WW+2)'(s_c) > (WW+2)'(h_c))) begin
            yl_r <= yl_r + (WW+2)'(s_c);
            state_r <= ST_NEXT;
          end else begin
            if (pv_r) sad_r <= sad_r + (SAD_W+1)'(dif);
            if (state_r == ST_SAD) begin
              pv_r <= 1'b1;
              if (last_xy) state_r <= ST_SAD_END;
              if (last_y) begin
                iy_r <= '0; ix_r <= ix_r + SSW'(1);
              end else iy_r <= iy_r + SSW'(1);
            end else if (pv_r) begin
              pv_r <= 1'b0;
            end else begin
              if (sad_r < best_r) begin
                best_r <= sad_r; bx_r <= px_r[7:0]; by_r <= py_r[7:0]; found_r <= 1'b1;
              end
              yl_r <= yl_r + (WW+2)'(s_c);
              state_r <= ST_NEXT;
            end
          end
        end
        ST_DONE: begin
          out_v_r <= 1'b1;
          out_r.found    <= found_r;
          out_r.match_x  <= found_r ? bx_r : 8'd0;
          out_r.match_y  <= found_r ? by_r : 8'd0;
          out_r.best_sad <= found_r ? best_r[SAD_W-1:0] : '0;
          state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end
endmodule

// File: tb/sv/grid_peak_sad_template_match_tb.sv
// Self-checking testbench for the grid peak SAD template matcher.
module grid_peak_sad_template_match_top_tb;
  import gpsm_pkg::*;

  localparam logic [1:0] CFG_SPARE = 2'd3;  // unmapped register index
  localparam int LIM_W = 256;
  localparam int LIM_H = 256;
  localparam int LIM_S = 64;

  // Scoreboard: mirrors the stores and registers, predicts one word per start
  class sad_scoreboard;
    logic [7:0]  pix_mem[LIM_W*LIM_H];
    logic [31:0] score_mem[LIM_W*LIM_H];
    logic [7:0]  tmpl_mem[LIM_S*LIM_S];
    logic [8:0]  img_w, img_h;
    logic [6:0]  cell_s;
    out_word_t   pending[$];
    int          errors;

    function new();
      img_w = 9'd256;
      img_h = 9'd256;
      cell_s = 7'd16;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [8:0] val);
      case (idx)
        CFG_WIDTH:  img_w = val;
        CFG_HEIGHT: img_h = val;
        CFG_SUB:    cell_s = val[6:0];
        default: ;
      endcase
    endfunction

    // Cell walk: peak per cell, then SAD at that peak, keep strictly smallest
    function out_word_t match_search();
      int unsigned w, h, s, best, bx, by, px, py, sad, a, b;
      logic [31:0] peak, v;
      bit hit;
      out_word_t r;
      w = (img_w == 0) ? 1 : (img_w > LIM_W) ? LIM_W : img_w;
      h = (img_h == 0) ? 1 : (img_h > LIM_H) ? LIM_H : img_h;
      s = (cell_s == 0) ? 1 : (cell_s > LIM_S) ? LIM_S : cell_s;
      best = s * s * 256;
      bx = 0;
      by = 0;
      hit = 0;
      for (int unsigned xl = 0; xl + s <= w; xl += s) begin
        for (int unsigned yl = 0; yl + s <= h; yl += s) begin
          px = xl;
          py = yl;
          peak = score_mem[yl*LIM_W + xl];
          for (int unsigned x = xl; x < xl + s; x++)
            for (int unsigned y = yl; y < yl + s; y++) begin
              v = score_mem[y*LIM_W + x];
              if ($signed(v) > $signed(peak)) begin
                peak = v;
                px = x;
                py = y;
              end
            end
          if (px + s > w || py + s > h) continue;
          sad = 0;
          for (int unsigned x = 0; x < s; x++)
            for (int unsigned y = 0; y < s; y++) begin
              a = tmpl_mem[y*LIM_S + x];
              b = pix_mem[(py + y)*LIM_W + px + x];
              sad += (a > b) ? a - b : b - a;
            end
          if (sad < best) begin
            best = sad;
            bx = px;
            by = py;
            hit = 1;
          end
        end
      end
      r = '0;
      if (hit) begin
        r.found = 1'b1;
        r.match_x = bx[7:0];
        r.match_y = by[7:0];
        r.best_sad = best[20:0];
      end
      return r;
    endfunction

    function void note_input(in_word_t wd);
      case (req_t'(wd.req_type))
        REQ_LOAD_LARGE: begin
          pix_mem[wd.pos_y*LIM_W + wd.pos_x] = wd.pixel;
          score_mem[wd.pos_y*LIM_W + wd.pos_x] = wd.corr_score;
        end
        REQ_LOAD_SUB:
          if (wd.pos_x < LIM_S && wd.pos_y < LIM_S)
            tmpl_mem[wd.pos_y*LIM_S + wd.pos_x] = wd.pixel;
        REQ_START: pending.push_back(match_search());
        default: ;
      endcase
    endfunction

    function void check_result(out_word_t got);
      out_word_t exp_w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result word %p", $time, got);
        errors++;
        return;
      end
      exp_w = pending.pop_front();
      if (got.found !== exp_w.found) begin
        $display("%0t: found exp %0d got %0d", $time, exp_w.found, got.found);
        errors++;
      end
      if (got.match_x !== exp_w.match_x) begin
        $display("%0t: match_x exp %0d got %0d", $time, exp_w.match_x, got.match_x);
        errors++;
      end
      if (got.match_y !== exp_w.match_y) begin
        $display("%0t: match_y exp %0d got %0d", $time, exp_w.match_y, got.match_y);
        errors++;
      end
      if (got.best_sad !== exp_w.best_sad) begin
        $display("%0t: best_sad exp %0d got %0d", $time, exp_w.best_sad, got.best_sad);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  gpsm_in_if  in_ch();
  gpsm_out_if out_ch();
  gpsm_cfg_if cfg_ch();

  grid_peak_sad_template_match_top DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  sad_scoreboard sb = new();
  bit pix_written[LIM_W*LIM_H];
  bit tmpl_written[LIM_S*LIM_S];
  int unsigned use_w, use_h, use_s;
  bit tx_burst;
  int rx_count;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Send one input word after a random gap
  task automatic send_word(in_word_t wd);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= wd;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(wd);
    if (wd.req_type == REQ_LOAD_LARGE) pix_written[wd.pos_y*LIM_W + wd.pos_x] = 1;
    if (wd.req_type == REQ_LOAD_SUB && wd.pos_x < LIM_S && wd.pos_y < LIM_S)
      tmpl_written[wd.pos_y*LIM_S + wd.pos_x] = 1;
  endtask

  task automatic send_load(req_t rq, int x, int y, int pix, logic [31:0] sc);
    in_word_t wd;
    wd.req_type = rq;
    wd.pos_x = x[7:0];
    wd.pos_y = y[7:0];
    wd.pixel = pix[7:0];
    wd.corr_score = sc;
    send_word(wd);
  endtask

  task automatic send_start();
    send_load(REQ_START, $urandom, $urandom, $urandom, $urandom);
  endtask

  function automatic logic [31:0] draw_score();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 3);
      2: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return -$urandom_range(1, 4);
    endcase
  endfunction

  // Wait for outstanding results, then let the block settle
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Register write; the input side is held idle meanwhile
  task automatic write_reg(logic [1:0] idx, logic [8:0] val);
    in_ch.valid <= 1'b0;
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= '{index: idx, data: val};
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  // New register setting; then make sure every store entry a search reads is written
  task automatic set_geometry(int w, int h, int s);
    wait_idle();
    write_reg(CFG_WIDTH, w[8:0]);
    write_reg(CFG_HEIGHT, h[8:0]);
    write_reg(CFG_SUB, s[8:0]);
    use_w = (w == 0) ? 1 : (w > LIM_W) ? LIM_W : w;
    use_h = (h == 0) ? 1 : (h > LIM_H) ? LIM_H : h;
    use_s = (s[6:0] == 0) ? 1 : (s[6:0] > LIM_S) ? LIM_S : s[6:0];
    for (int y = 0; y < use_h; y++)
      for (int x = 0; x < use_w; x++)
        if (!pix_written[y*LIM_W + x])
          send_load(REQ_LOAD_LARGE, x, y, $urandom, draw_score());
    // the sub-image is read only when a cell fits on the image
    if (use_s <= use_w && use_s <= use_h)
      for (int y = 0; y < use_s; y++)
        for (int x = 0; x < use_s; x++)
          if (!tmpl_written[y*LIM_S + x])
            send_load(REQ_LOAD_SUB, x, y, $urandom, 0);
  endtask

  // Random traffic: mostly loads on the active image, some starts and noise
  task automatic random_traffic(int count);
    int n, r, x, y;
    logic [63:0] rnd;
    in_word_t wd;
    n = 0;
    while (n < count) begin
      if (n % 40 == 0) tx_burst = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 50) begin
        if ($urandom_range(0, 4) != 0) begin
          x = $urandom_range(0, use_w - 1);
          y = $urandom_range(0, use_h - 1);
        end else begin
          x = $urandom_range(0, 255);
          y = $urandom_range(0, 255);
        end
        send_load(REQ_LOAD_LARGE, x, y, $urandom, draw_score());
        n++;
      end else if (r < 78) begin
        if ($urandom_range(0, 4) != 0) begin
          x = $urandom_range(0, use_s - 1);
          y = $urandom_range(0, use_s - 1);
        end else begin
          x = $urandom_range(0, 255);
          y = $urandom_range(0, 255);
        end
        send_load(REQ_LOAD_SUB, x, y, $urandom, $urandom);
        n++;
      end else if (r < 88) begin
        send_start();
        n++;
      end else begin
        rnd = {$urandom, $urandom};
        wd = rnd[$bits(in_word_t)-1:0];
        wd.req_type = REQ_NONE;
        send_word(wd);
      end
    end
  endtask

  // Result side: random stalls, one long hold-off so the input side backs up
  initial begin
    int gap;
    bit rx_burst;
    out_ch.ready <= 1'b0;
    rx_count = 0;
    rx_burst = 0;
    @(posedge rst_n);
    forever begin
      if ($urandom_range(0, 7) == 0) rx_burst = !rx_burst;
      gap = (rx_count == 20) ? 600 : rx_burst ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      sb.check_result(out_ch.data);
      rx_count++;
    end
  end

  initial begin
    #60_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int guard;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data <= '0;
    tx_burst = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: cell larger than image gives not-found
    set_geometry(4, 4, 2);
    write_reg(CFG_SUB, 9'd5);
    send_start();
    wait_idle();
    write_reg(CFG_SUB, 9'd2);
    // flat scores: peak at cell origin; identical windows tie, first wins
    for (int y = 0; y < 4; y++)
      for (int x = 0; x < 4; x++)
        send_load(REQ_LOAD_LARGE, x, y, ((x + y) % 2) ? 255 : 0, 32'h0001_0000);
    send_load(REQ_LOAD_SUB, 0, 0, 255, 0);
    send_load(REQ_LOAD_SUB, 1, 1, 255, 0);
    send_start();
    // extreme scores: peak at the bottom right edge runs off the image
    send_load(REQ_LOAD_LARGE, 3, 3, 0, 32'h7fff_ffff);
    send_load(REQ_LOAD_LARGE, 0, 0, 255, 32'h8000_0000);
    send_load(REQ_LOAD_SUB, 64, 200, 9, 0);
    send_load(REQ_LOAD_LARGE, 255, 255, 255, 32'hffff_ffff);
    send_start();
    wait_idle();
    write_reg(CFG_SPARE, 9'h1ff);
    send_start();

    // Register extremes, with clamping of out-of-range values
    set_geometry(511, 1, 1);
    random_traffic(40);
    set_geometry(1, 300, 0);
    random_traffic(40);
    set_geometry(16, 8, 127);
    random_traffic(20);
    set_geometry(4, 2, 2);
    random_traffic(30);

    // Random settings on small images
    for (int p = 0; p < 8; p++) begin
      set_geometry($urandom_range(1, 12), $urandom_range(1, 12), $urandom_range(1, 6));
      random_traffic(25);
    end

    // Drain
    in_ch.valid <= 1'b0;
    guard = 0;
    while (sb.pending.size() != 0 && guard < 2_000_000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/gpsm_pkg.sv
hdl/gpsm_if.sv
hdl/grid_peak_sad_template_match_top.sv
tb/sv/grid_peak_sad_template_match_tb.sv
